// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset as disable condition.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the following clock.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lpfd_pkg.sv =====
// Types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int STORE_DEPTH  = HEADER_BYTES - 1;
   localparam int CNT_W        = $clog2(HEADER_BYTES);
   localparam int IDX_W        = 8;
   localparam int DATA_W       = 32;

   localparam logic [7:0]  RST_MAGIC_FIRST  = 8'd0;
   localparam logic [7:0]  RST_MAGIC_SECOND = 8'd0;
   localparam logic [7:0]  RST_VERSION      = 8'd1;
   localparam logic [31:0] RST_MAX_LENGTH   = 32'd1048576;

   typedef enum logic [IDX_W-1:0] {
      CSR_MAGIC_FIRST  = 8'd0,
      CSR_MAGIC_SECOND = 8'd1,
      CSR_VERSION      = 8'd2,
      CSR_MAX_LENGTH   = 8'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_MAGIC   = 2'd1,
      ERR_VERSION = 2'd2,
      ERR_LENGTH  = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_ERROR   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  magic_first;
      logic [7:0]  magic_second;
      logic [7:0]  accepted_version;
      logic [31:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      logic        vld;
      kind_type    item_kind;
      err_type     error_code;
      logic [7:0]  frame_version;
      logic [7:0]  message_type;
      logic [31:0] request_id;
      logic [31:0] payload_length;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
   } res_type;

endpackage

// ===== hdl/lpfd_parse.sv =====
// Input register, header collection, checks and payload count.
module lpfd_parse import lpfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  cfg_type    cfg,
   input  logic       out_space,
   output res_type    res
);

   logic             in_vld_ff, in_vld_in;
   logic [7:0]       in_byte_ff;
   logic [7:0]       hdr_ff [STORE_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_eff;
   logic [31:0]      rem_ff, rem_in, rem_dec;
   phase_type        phase_ff, phase_in;
   logic             advance, hdr_wr;
   logic [31:0]      len;
   err_type          err;

   assign advance   = in_vld_ff && out_space;
   assign req_stall = in_vld_ff && !out_space;
   assign in_vld_in = (req_valid && !req_stall) ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

   // count wraps on a corrupt value, as a fresh header
   assign cnt_eff = (cnt_ff >= CNT_W'(HEADER_BYTES)) ? '0 : cnt_ff;
   assign len     = {hdr_ff[8], hdr_ff[9], hdr_ff[10], in_byte_ff};
   assign rem_dec = rem_ff - 32'd1;

   always_comb begin
      if (hdr_ff[0] != cfg.magic_first || hdr_ff[1] != cfg.magic_second) begin
         err = ERR_MAGIC;
      end else if (hdr_ff[2] != cfg.accepted_version) begin
         err = ERR_VERSION;
      end else if (len > cfg.max_payload_length) begin
         err = ERR_LENGTH;
      end else begin
         err = ERR_NONE;
      end
   end

   always_comb begin
      res      = '0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      hdr_wr   = 1'b0;
      if (advance) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               res.vld          = 1'b1;
               res.item_kind    = KIND_PAYLOAD;
               res.payload_byte = in_byte_ff;
               rem_in           = rem_dec;
               if (rem_dec == 32'd0) begin
                  res.last_of_frame = 1'b1;
                  phase_in          = PH_HEADER;
                  cnt_in            = '0;
               end
            end
            PH_HEADER: begin
               if (cnt_eff != CNT_W'(STORE_DEPTH)) begin
                  hdr_wr = 1'b1;
                  cnt_in = cnt_eff + CNT_W'(1);
               end else begin
                  cnt_in  = '0;
                  res.vld = 1'b1;
                  if (err != ERR_NONE) begin
                     res.item_kind  = KIND_ERROR;
                     res.error_code = err;
                     phase_in       = PH_ERROR;
                  end else begin
                     res.item_kind      = KIND_HEADER;
                     res.frame_version  = hdr_ff[2];
                     res.message_type   = hdr_ff[3];
                     res.request_id     = {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]};
                     res.payload_length = len;
                     if (len == 32'd0) begin
                        res.last_of_frame = 1'b1;
                     end else begin
                        rem_in   = len;
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
            default: begin
               // error latched: byte dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cnt_ff    <= '0;
         rem_ff    <= '0;
         phase_ff  <= PH_HEADER;
      end else begin
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
         rem_ff    <= rem_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (hdr_wr) begin
         hdr_ff[cnt_eff] <= in_byte_ff;
      end
   end

endmodule

// ===== hdl/lpfd_out.sv =====
// Result register towards the rsp channel.
module lpfd_out import lpfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  res_type     res,
   output logic        out_space,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_item_kind,
   output logic [1:0]  rsp_error_code,
   output logic [7:0]  rsp_frame_version,
   output logic [7:0]  rsp_message_type,
   output logic [31:0] rsp_request_id,
   output logic [31:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_frame
);

   logic    vld_ff, vld_in;
   res_type out_ff;

   assign out_space = !vld_ff || !rsp_stall;
   assign vld_in    = out_space ? res.vld : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_space && res.vld) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = vld_ff;
   assign rsp_item_kind      = out_ff.item_kind;
   assign rsp_error_code     = out_ff.error_code;
   assign rsp_frame_version  = out_ff.frame_version;
   assign rsp_message_type   = out_ff.message_type;
   assign rsp_request_id     = out_ff.request_id;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_last_of_frame  = out_ff.last_of_frame;

endmodule

// ===== hdl/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer: config registers and pipeline.
//
//   channel   handshake                fields
//   req       req_valid / req_stall    req_data_byte
//   rsp       rsp_valid / rsp_stall    rsp_item_kind ... rsp_last_of_frame
//   csr       csr_valid / csr_ready    csr_index, csr_wdata
//
// One word per cycle sustained while rsp_stall is low; a result word passes the input
// register, then the result register, from which it is offered on rsp. Header words
// but the last give no result; the last gives the header or error result.
// Reset sets the header phase and clears header count, remaining count and valids.
// req_stall rises only when the input register is full and the result register is
// held by rsp_stall. csr_ready is always high.
module length_prefixed_frame_deframer import lpfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_item_kind,
   output logic [1:0]        rsp_error_code,
   output logic [7:0]        rsp_frame_version,
   output logic [7:0]        rsp_message_type,
   output logic [31:0]       rsp_request_id,
   output logic [31:0]       rsp_payload_length,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_last_of_frame,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   res_type res;
   logic    out_space;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAGIC_FIRST:  cfg_in.magic_first        = csr_wdata[7:0];
            CSR_MAGIC_SECOND: cfg_in.magic_second       = csr_wdata[7:0];
            CSR_VERSION:      cfg_in.accepted_version   = csr_wdata[7:0];
            CSR_MAX_LENGTH:   cfg_in.max_payload_length = csr_wdata;
            default: begin
               // unknown index: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first        <= RST_MAGIC_FIRST;
         cfg_ff.magic_second       <= RST_MAGIC_SECOND;
         cfg_ff.accepted_version   <= RST_VERSION;
         cfg_ff.max_payload_length <= RST_MAX_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpfd_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .cfg           (cfg_ff),
      .out_space     (out_space),
      .res           (res)
   );

   lpfd_out u_out (
      .clock              (clock),
      .reset              (reset),
      .res                (res),
      .out_space          (out_space),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_error_code     (rsp_error_code),
      .rsp_frame_version  (rsp_frame_version),
      .rsp_message_type   (rsp_message_type),
      .rsp_request_id     (rsp_request_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

endmodule

// ===== hdl/lpfd_checker.sv =====
// Port-level checks of the deframer and their bind to the top level.
`include "assert_macros.svh"

module lpfd_checker import lpfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_item_kind,
   input logic [1:0]  rsp_error_code,
   input logic [7:0]  rsp_frame_version,
   input logic [7:0]  rsp_message_type,
   input logic [31:0] rsp_request_id,
   input logic [31:0] rsp_payload_length,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_last_of_frame
);

   logic [92:0] rsp_word;
   logic        rsp_held, rsp_err, rsp_hdr, hdr_empty;

   assign rsp_word  = {rsp_item_kind, rsp_error_code, rsp_frame_version, rsp_message_type,
                       rsp_request_id, rsp_payload_length, rsp_payload_byte,
                       rsp_last_of_frame};
   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_err   = rsp_valid && rsp_item_kind == KIND_ERROR;
   assign rsp_hdr   = rsp_valid && rsp_item_kind == KIND_HEADER;
   assign hdr_empty = rsp_payload_length == 32'd0;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word), "stalled result changed")

   `ASSERT_CLK(a_err_form, clock, reset, rsp_err |-> rsp_error_code != ERR_NONE && !rsp_last_of_frame, "bad error result")

   `ASSERT_CLK(a_hdr_last, clock, reset, rsp_hdr |-> rsp_last_of_frame == hdr_empty, "header last flag wrong")

   `ASSERT_NEXT(a_err_final, clock, reset, rsp_err && !rsp_stall, !rsp_valid, "result after error report")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);
